@@ rtl/ffha_pkg.sv @@
`default_nettype none
package ffha_pkg;
  localparam int unsigned HoleCountDef = 128;
  localparam int unsigned GranuleDef   = 8;
  localparam int unsigned AddrBitsDef  = 48;
  localparam int unsigned FieldBits    = 48;
  localparam logic [7:0]  HeaderReset  = 8'd16;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_LEAK    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_AREAD, S_ACHECK, S_FREAD, S_FCHECK, S_FNEXT,
    S_FMERGE, S_FTAIL, S_FINS, S_RELINK, S_OUT
  } fsm_t;
endpackage
`default_nettype wire

@@ rtl/first_fit_hole_allocator_core.sv @@
`default_nettype none
// First-fit hole allocator. An item walks the address-sorted hole list one
// descriptor at a time through the single-read-port descriptor table: each
// descriptor is read in one state and tested in the next. At most HoleCount
// holes are walked per item, and a new item is taken only after the last result has left.
// After reset the link table is initialized by a pass over all HoleCount entries,
// during which no item is taken. in_stall is high whenever an item is in work.
module first_fit_hole_allocator_core import ffha_pkg::*; #(
  parameter int unsigned HoleCount = HoleCountDef,
  parameter int unsigned Granule   = GranuleDef,
  parameter int unsigned AddrBits  = AddrBitsDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 kind,
  input  wire logic [FieldBits-1:0] req_size,
  input  wire logic [FieldBits-1:0] block_addr,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [FieldBits-1:0]      result_addr,
  output logic [FieldBits-1:0]      granted_size,
  output logic [1:0]                status
);
  localparam int unsigned IdxBits  = $clog2(HoleCount);
  localparam int unsigned LinkBits = $clog2(HoleCount + 1);
  localparam logic [LinkBits-1:0] Nil = LinkBits'(HoleCount);
  localparam int unsigned WBits = (AddrBits > FieldBits ? AddrBits : FieldBits) + 2;
  localparam logic [AddrBits-1:0] AMax = '1;

  fsm_t state, state_next;
  logic [7:0]          header_bytes;
  logic [LinkBits-1:0] used_head, spare_head, cur, prev, cnt, succ;
  logic [WBits-1:0]    need;
  logic [AddrBits-1:0] faddr, ftop, mend;

  logic [IdxBits-1:0]  rd_idx;
  logic [AddrBits-1:0] rd_start, rd_end;
  logic [LinkBits-1:0] rd_link;
  logic st_we, en_we, ln_we;
  logic [IdxBits-1:0] st_idx, en_idx, ln_idx;
  logic [AddrBits-1:0] st_data, en_data;
  logic [LinkBits-1:0] ln_data;

  ffha_table #(.HoleCount(HoleCount), .AddrBits(AddrBits)) u_table (
    .clk, .rd_idx, .rd_start, .rd_end, .rd_link,
    .st_we, .st_idx, .st_data, .en_we, .en_idx, .en_data,
    .ln_we, .ln_idx, .ln_data
  );

  // request rounding and freed-region clipping, combinational on the inputs
  logic [WBits-1:0] need_w, f_a, f_l, f_sum;
  logic [AddrBits-1:0] f_top;
  always_comb begin
    need_w = WBits'(req_size) + WBits'(header_bytes) + WBits'(Granule);
    need_w = need_w - (need_w % WBits'(Granule));
    f_a   = WBits'(AddrBits'(block_addr));
    f_l   = WBits'(AddrBits'(req_size));
    f_sum = f_a + f_l;
    f_top = (f_sum > WBits'(AMax)) ? AMax : AddrBits'(f_sum);
  end

  // fit test and carve end on the descriptor just read
  logic [WBits-1:0] span_w, carve_end;
  logic fit, emptied;
  always_comb begin
    span_w    = WBits'(rd_end - rd_start);
    carve_end = WBits'(rd_start) + need;
    fit       = (span_w >= need);
    emptied   = (carve_end == WBits'(rd_end));
  end

  logic accept_in;
  assign accept_in = (state == S_IDLE) && in_valid;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      header_bytes <= HeaderReset;
      used_head <= Nil;
      spare_head <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) header_bytes <= cfg_wdata;
      if (state == S_INIT) cnt <= cnt + 1'b1;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept_in) begin
        prev <= Nil;
        cur  <= used_head;
        cnt  <= '0;
        result_addr  <= '0;
        granted_size <= '0;
        need  <= need_w;
        faddr <= AddrBits'(block_addr);
        ftop  <= f_top;
        if (!kind) begin
          state <= (used_head == Nil) ? S_OUT : S_AREAD;
          status <= ST_NOFIT;
          if (used_head == Nil) out_valid <= 1'b1;
        end else if (f_l == '0 || f_top == AddrBits'(block_addr)) begin
          state <= S_OUT; status <= ST_IGNORED; out_valid <= 1'b1;
        end else begin
          state <= (used_head == Nil) ? S_FTAIL : S_FREAD;
          status <= ST_DONE;
        end
      end
      case (state)
        S_ACHECK: begin
          if (fit) begin
            result_addr  <= FieldBits'(rd_start);
            granted_size <= FieldBits'(need);
            status <= ST_DONE;
            out_valid <= 1'b1;
            if (emptied) begin
              if (prev == Nil) used_head <= rd_link;
              spare_head <= cur;
              succ <= rd_link;
            end
          end else begin
            prev <= cur; cur <= rd_link; cnt <= cnt + 1'b1;
            if (rd_link == Nil || cnt == LinkBits'(HoleCount - 1)) out_valid <= 1'b1;
          end
        end
        S_FCHECK: begin
          if (rd_end == faddr) begin
            mend <= ftop; prev <= cur; cur <= rd_link;
            if (rd_link == Nil) out_valid <= 1'b1;
          end else if (rd_start > faddr) begin
            if (ftop == rd_start) out_valid <= 1'b1;
          end else begin
            prev <= cur; cur <= rd_link; cnt <= cnt + 1'b1;
          end
        end
        S_FMERGE: begin
          // prev holds the merged hole, cur its successor
          out_valid <= 1'b1;
          if (mend == rd_start) begin
            spare_head <= cur;
            succ <= rd_link;
          end
        end
        S_FINS: begin
          out_valid <= 1'b1;
          if (spare_head == Nil) status <= ST_LEAK;
          else begin
            spare_head <= rd_link;
            succ <= spare_head;
            if (prev == Nil) used_head <= spare_head;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    rd_idx = IdxBits'(cur);
    st_we = 1'b0; en_we = 1'b0; ln_we = 1'b0;
    st_idx = IdxBits'(cur); en_idx = IdxBits'(cur); ln_idx = IdxBits'(cur);
    st_data = rd_start; en_data = rd_end; ln_data = rd_link;
    case (state)
      S_INIT: begin
        ln_we = 1'b1; ln_idx = IdxBits'(cnt); ln_data = cnt + 1'b1;
        if (cnt == LinkBits'(HoleCount - 1)) state_next = S_IDLE;
      end
      S_IDLE: ;
      S_AREAD: state_next = S_ACHECK;
      S_ACHECK: begin
        if (fit) begin
          state_next = (emptied && prev != Nil) ? S_RELINK : S_OUT;
          st_we = 1'b1; st_data = AddrBits'(carve_end);
          if (emptied) begin
            ln_we = 1'b1; ln_data = spare_head;
          end
        end else if (rd_link == Nil || cnt == LinkBits'(HoleCount - 1)) begin
          state_next = S_OUT;
        end else state_next = S_AREAD;
      end
      S_FREAD: state_next = S_FCHECK;
      S_FCHECK: begin
        if (rd_end == faddr) begin
          en_we = 1'b1; en_data = ftop;
          state_next = (rd_link == Nil) ? S_OUT : S_FNEXT;
        end else if (rd_start > faddr) begin
          if (ftop == rd_start) begin
            st_we = 1'b1; st_data = faddr; state_next = S_OUT;
          end else state_next = S_FTAIL;
        end else if (rd_link == Nil || cnt == LinkBits'(HoleCount - 1)) begin
          state_next = S_FTAIL;
        end else state_next = S_FREAD;
      end
      S_FNEXT: state_next = S_FMERGE;
      S_FMERGE: begin
        state_next = S_OUT;
        if (mend == rd_start) begin
          en_we = 1'b1; en_idx = IdxBits'(prev); en_data = rd_end;
          ln_we = 1'b1; ln_data = spare_head;
          state_next = S_RELINK;
        end
      end
      S_FTAIL: begin
        // read spare head's link; cur is the successor (maybe Nil)
        rd_idx = IdxBits'(spare_head);
        state_next = S_FINS;
      end
      S_FINS: begin
        state_next = S_OUT;
        if (spare_head != Nil) begin
          st_we = 1'b1; st_idx = IdxBits'(spare_head); st_data = faddr;
          en_we = 1'b1; en_idx = IdxBits'(spare_head); en_data = ftop;
          ln_we = 1'b1; ln_idx = IdxBits'(spare_head);
          ln_data = (cur >= Nil) ? Nil : cur;
          if (prev != Nil) state_next = S_RELINK;
        end
      end
      S_RELINK: begin
        // point the predecessor at its new successor
        ln_we = 1'b1; ln_idx = IdxBits'(prev); ln_data = succ;
        state_next = S_OUT;
      end
      S_OUT: if (!out_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_IDLE && in_valid) state_next = state;
  end
endmodule
`default_nettype wire

@@ rtl/ffha_table.sv @@
`default_nettype none
// Descriptor storage: start, end and link arrays, one read port, one write port each.
module ffha_table import ffha_pkg::*; #(
  parameter int unsigned HoleCount = HoleCountDef,
  parameter int unsigned AddrBits  = AddrBitsDef,
  localparam int unsigned IdxBits  = $clog2(HoleCount),
  localparam int unsigned LinkBits = $clog2(HoleCount + 1)
) (
  input  wire logic                clk,
  input  wire logic [IdxBits-1:0]  rd_idx,
  output logic      [AddrBits-1:0] rd_start,
  output logic      [AddrBits-1:0] rd_end,
  output logic      [LinkBits-1:0] rd_link,
  input  wire logic                st_we,
  input  wire logic [IdxBits-1:0]  st_idx,
  input  wire logic [AddrBits-1:0] st_data,
  input  wire logic                en_we,
  input  wire logic [IdxBits-1:0]  en_idx,
  input  wire logic [AddrBits-1:0] en_data,
  input  wire logic                ln_we,
  input  wire logic [IdxBits-1:0]  ln_idx,
  input  wire logic [LinkBits-1:0] ln_data
);
  logic [AddrBits-1:0] start_mem [HoleCount];
  logic [AddrBits-1:0] end_mem   [HoleCount];
  logic [LinkBits-1:0] link_mem  [HoleCount];

  always_ff @(posedge clk) begin
    if (st_we) start_mem[st_idx] <= st_data;
    if (en_we) end_mem[en_idx] <= en_data;
    if (ln_we) link_mem[ln_idx] <= ln_data;
    rd_start <= start_mem[rd_idx];
    rd_end   <= end_mem[rd_idx];
    rd_link  <= link_mem[rd_idx];
  end
endmodule
`default_nettype wire

@@ rtl/ffha_checker.sv @@
`default_nettype none
module ffha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [47:0] result_addr,
  input wire logic [47:0] granted_size,
  input wire logic [1:0]  status
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_addr))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 2'd0 |-> result_addr == '0 && granted_size == '0)
    else $error("failed item carries data");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid) else $error("result beat repeated");
endmodule

bind first_fit_hole_allocator_core ffha_checker u_ffha_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .result_addr, .granted_size, .status
);
`default_nettype wire

@@ dv/first_fit_hole_allocator_core_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module first_fit_hole_allocator_core_tb;
  import ffha_pkg::*;

  localparam int unsigned Holes = HoleCountDef;
  localparam int unsigned Gran = GranuleDef;
  localparam logic [47:0] AddrMask = 48'hFFFF_FFFF_FFFF;
  localparam int NumItems = 1100;

  typedef enum logic {K_ALLOC = 1'b0, K_FREE = 1'b1} kind_t;

  typedef struct packed {
    logic [47:0] addr;
    logic [47:0] size;
    status_t     st;
  } grant_t;

  // Behavioral copy of the hole table; predicts one grant per beat.
  class hole_scoreboard;
    logic [47:0] h_start[Holes];
    logic [47:0] h_end[Holes];
    int unsigned link[Holes];
    int unsigned used_head, spare_head;
    logic [7:0] hdr;
    grant_t pending[$];
    int errors, checked;

    function new();
      for (int i = 0; i < Holes; i++) begin
        h_start[i] = '0;
        h_end[i] = '0;
        link[i] = i + 1;
      end
      used_head = Holes;
      spare_head = 0;
      hdr = HeaderReset;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned hole_count();
      int unsigned h, n;
      h = used_head;
      n = 0;
      while (h < Holes) begin
        n++;
        h = link[h];
      end
      return n;
    endfunction

    function void retire(int unsigned d);
      link[d] = spare_head;
      spare_head = d;
    endfunction

    function grant_t carve(logic [47:0] req);
      grant_t g;
      logic [63:0] need;
      int unsigned prv, h;
      g = '{addr: '0, size: '0, st: ST_NOFIT};
      need = 64'(req) + 64'(hdr) + 64'(Gran);
      need = need - (need % 64'(Gran));
      prv = Holes;
      h = used_head;
      for (int n = 0; h < Holes && n < Holes; n++) begin
        if (64'(h_end[h] - h_start[h]) >= need) begin
          g.addr = h_start[h];
          g.size = need[47:0];
          g.st = ST_DONE;
          h_start[h] = h_start[h] + need[47:0];
          if (h_start[h] == h_end[h]) begin
            if (prv == Holes) used_head = link[h];
            else link[prv] = link[h];
            retire(h);
          end
          return g;
        end
        prv = h;
        h = link[h];
      end
      return g;
    endfunction

    function status_t release_region(logic [47:0] a, logic [47:0] len);
      logic [47:0] top;
      int unsigned prv, h, c, d;
      if (len == 0) return ST_IGNORED;
      top = (len > AddrMask - a) ? AddrMask : a + len;
      if (top == a) return ST_IGNORED;
      prv = Holes;
      h = used_head;
      for (int n = 0; h < Holes && n < Holes; n++) begin
        if (h_end[h] == a) begin
          h_end[h] = top;
          c = link[h];
          if (c < Holes && h_end[h] == h_start[c]) begin
            h_end[h] = h_end[c];
            link[h] = link[c];
            retire(c);
          end
          return ST_DONE;
        end
        if (h_start[h] > a) break;
        prv = h;
        h = link[h];
      end
      if (h < Holes && top == h_start[h]) begin
        h_start[h] = a;
        return ST_DONE;
      end
      if (spare_head >= Holes) return ST_LEAK;
      d = spare_head;
      spare_head = link[d];
      h_start[d] = a;
      h_end[d] = top;
      link[d] = h;
      if (prv == Holes) used_head = d;
      else link[prv] = d;
      return ST_DONE;
    endfunction

    function void note_input(logic k, logic [47:0] sz, logic [47:0] a);
      grant_t g;
      if (k == K_ALLOC) g = carve(sz);
      else g = '{addr: '0, size: '0, st: release_region(a, sz)};
      pending.push_back(g);
    endfunction

    function void check_result(logic [47:0] a, logic [47:0] sz, logic [1:0] st);
      grant_t g;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: addr=%h size=%h status=%0d", a, sz, st);
        return;
      end
      g = pending.pop_front();
      checked++;
      if (g.addr !== a || g.size !== sz || g.st !== st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp addr=%h size=%h status=%0d, got addr=%h size=%h status=%0d",
                   checked, g.addr, g.size, g.st, a, sz, st);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [47:0] req_size = '0;
  logic [47:0] block_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [47:0] result_addr, granted_size;
  logic [1:0] status;

  int send_idle_pct = 0, recv_idle_pct = 0;
  int n_alloc = 0, n_free = 0;
  hole_scoreboard sb = new();

  always #5 clk = ~clk;

  first_fit_hole_allocator_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .req_size(req_size), .block_addr(block_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_addr(result_addr), .granted_size(granted_size), .status(status)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(result_addr, granted_size, status);
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Valid stays up across back-to-back beats; drop it only for idle cycles.
  task automatic send_beat(input logic k, input logic [47:0] sz, input logic [47:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    req_size <= sz;
    block_addr <= a;
    do @(posedge clk); while (in_stall);
    sb.note_input(k, sz, a);
    if (k == K_ALLOC) n_alloc++;
    else n_free++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * Holes + 20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.hdr = v;
  endtask

  // Random traffic in a small window so frees land next to existing holes.
  task automatic random_phase(input int count, input logic [47:0] base);
    logic [47:0] a, sz;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_beat(K_FREE, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      end else if (r < 5) begin
        send_beat(K_ALLOC, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      end else if (r < 50) begin
        sz = 48'($urandom_range(300));
        send_beat(K_ALLOC, sz, 48'({$urandom, $urandom}));
      end else begin
        a = base + 48'($urandom_range(4000) * Gran);
        sz = (r < 90) ? 48'($urandom_range(8) * Gran) : 48'($urandom_range(200));
        send_beat(K_FREE, sz, a);
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: reset header, empty table, extremes, clipping, merges
    send_beat(K_ALLOC, 48'd0, 48'd0);
    send_beat(K_FREE, 48'd0, 48'h1000);
    send_beat(K_FREE, 48'd64, 48'h1000);
    send_beat(K_FREE, 48'd64, 48'h1080);
    send_beat(K_FREE, 48'd64, 48'h1040);
    send_beat(K_FREE, 48'd64, 48'h0fc0);
    send_beat(K_ALLOC, 48'd0, 48'd0);
    send_beat(K_ALLOC, 48'd7, AddrMask);
    send_beat(K_ALLOC, AddrMask, 48'd0);
    send_beat(K_FREE, AddrMask, AddrMask);
    send_beat(K_FREE, 48'd100, AddrMask - 48'd10);
    send_beat(K_FREE, AddrMask, 48'd0);
    send_beat(K_ALLOC, 48'h7FFF_FFFF_FFF0, 48'd0);
    send_beat(K_ALLOC, 48'd1000, 48'd0);
    write_header(8'd0);
    send_beat(K_ALLOC, 48'd0, 48'd0);
    send_beat(K_ALLOC, 48'd5, 48'd0);
    write_header(8'd255);
    send_beat(K_ALLOC, 48'd1, 48'd0);
    // exhaust descriptors with disjoint regions, then hit the leak case
    for (int i = 0; i < Holes + 3; i++)
      send_beat(K_FREE, 48'd8, 48'h10_0000 + 48'(i * 32));
    send_beat(K_ALLOC, 48'd0, 48'd0);

    send_idle_pct = 36;
    recv_idle_pct = 48;
    random_phase(320, 48'h10_0000);
    write_header(8'd3);
    send_idle_pct = 48;
    recv_idle_pct = 36;
    random_phase(320, 48'h20_0000);
    write_header(8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(320, 48'h30_0000);
    drain();

    $display("covered %0d allocate and %0d free beats, %0d holes left in table",
             n_alloc, n_free, sb.hole_count());
    $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("first_fit_hole_allocator_core test passed");
    end else begin
      $display("first_fit_hole_allocator_core test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("first_fit_hole_allocator_core test failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/ffha_pkg.sv
rtl/ffha_table.sv
rtl/first_fit_hole_allocator_core.sv
rtl/ffha_checker.sv
dv/first_fit_hole_allocator_core_tb.sv
